// ----- hdl/veh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veh_pkg
// Types, constants and helpers shared by the variable-edge histogram.
// ----------------------------------------------------------------------------
package veh_pkg;

    localparam int MAX_EDGES = 16;
    localparam int NUM_BINS  = MAX_EDGES - 1;
    localparam int IDX_W     = $clog2(MAX_EDGES);
    localparam int TOT_W     = $clog2(MAX_EDGES + 1);
    localparam int CNT_W     = 32;
    localparam int VAL_W     = 32;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_COUNT = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IN_BIN  = 3'd0,
        ST_UNDER   = 3'd1,
        ST_OVER    = 3'd2,
        ST_EDGE    = 3'd3,
        ST_CLEARED = 3'd4,
        ST_REFUSED = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [VAL_W-1:0] edge_value;
        logic signed [VAL_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [2:0]              status;
        logic [IDX_W-1:0]        hit_bin;
        logic [IDX_W-1:0]        peak_bin;
        logic [CNT_W-1:0]        peak_count;
        logic signed [VAL_W-1:0] mode_value;
        logic [CNT_W-1:0]        below_total;
        logic [CNT_W-1:0]        above_total;
        logic [CNT_W-1:0]        sample_total;
        logic [TOT_W-1:0]        edges_held;
    } result_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                    do_insert;
        logic                    do_count;
        logic                    do_clear;
        logic signed [VAL_W-1:0] value;
        logic [TOT_W-1:0]        edge_total;
        logic [IDX_W-1:0]        best_bin;
        logic [CNT_W-1:0]        best_count;
    } cell_ctrl_t;

    typedef struct packed {
        logic                    le;
        logic                    hit;
        logic                    take;
        logic signed [VAL_W-1:0] edge_cur;
        logic signed [VAL_W-1:0] edge_upd;
        logic [CNT_W-1:0]        cnt_new;
        logic signed [VAL_W-1:0] mid;
    } cell_out_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

    // floor of the exact sum halved
    function automatic logic signed [VAL_W-1:0] mid_of(input logic signed [VAL_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return s[VAL_W:1];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/veh_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veh_cell
// One slot of the sorted edge row: holds an edge and the count of the bin
// that starts at it, compares against the broadcast value and shifts on insert.
// ----------------------------------------------------------------------------
module veh_cell
    import veh_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic [IDX_W-1:0]        cell_idx,
    input  wire cell_ctrl_t              ctrl,
    input  wire logic                    left_le,
    input  wire logic signed [VAL_W-1:0] left_edge,
    input  wire logic                    right_le,
    input  wire logic signed [VAL_W-1:0] right_edge,
    output cell_out_t                    cell_o
);

    logic signed [VAL_W-1:0] edge_reg;
    logic signed [VAL_W-1:0] edge_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    occupied;
    logic                    le;
    logic                    hit;
    logic [CNT_W-1:0]        cnt_inc;
    logic                    take;

    always_comb begin
        occupied = TOT_W'(cell_idx) < ctrl.edge_total;
        le       = occupied && (edge_reg <= ctrl.value);
        // bin of this cell: sample at or above this edge, below the next stored one
        hit      = ctrl.do_count && le && !right_le
                   && ((TOT_W'(cell_idx) + TOT_W'(1)) < ctrl.edge_total);
        cnt_inc  = sat_inc(count_reg);
        take     = (cell_idx == ctrl.best_bin) || (cnt_inc > ctrl.best_count)
                   || ((cnt_inc == ctrl.best_count) && (cell_idx < ctrl.best_bin));
    end

    always_comb begin
        edge_next = edge_reg;
        // cells left of the insert point keep their edge, the rest move right
        if (ctrl.do_insert && !le) begin
            edge_next = left_le ? ctrl.value : left_edge;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.do_clear) begin
            count_next = '0;
        end else if (hit) begin
            count_next = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        edge_reg <= edge_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        cell_o.le       = le;
        cell_o.hit      = hit;
        cell_o.take     = take;
        cell_o.edge_cur = edge_reg;
        cell_o.edge_upd = edge_next;
        cell_o.cnt_new  = cnt_inc;
        cell_o.mid      = mid_of(edge_reg, right_edge);
    end

endmodule
`default_nettype wire

// ----- hdl/veh_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// veh_out_buf
// Two-entry result stage: an output register plus a skid register, so the
// input side keeps taking transactions while one result waits.
// ----------------------------------------------------------------------------
module veh_out_buf
    import veh_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         push_ready,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !m_ready) begin
            if (push) begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign push_ready = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_data_reg;

endmodule
`default_nettype wire

// ----- hdl/variable_edge_histogram_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_edge_histogram_top
// Histogram over up to 16 sorted, non-uniform signed Q16.16 bin edges.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle (clear, add edge or count sample) and returns
// one result per transaction, registered in the output stage. On acceptance
// the row of MAX_EDGES cells compares the value in parallel, shifts edges for a
// sorted insert and bumps at most one bin count, while the peak bin, peak count
// and mode are kept up to date from the bumped bin (on an insert, the mode from
// the first bin). A two-entry output stage lets input keep flowing while one
// result waits on m_ready; input stalls only when both entries are full. There
// is no clearing pass; clear takes effect in the same cycle.
// ----------------------------------------------------------------------------
module variable_edge_histogram_top
    import veh_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output result_t       m_data
);

    logic                    accept;
    cell_ctrl_t              ctrl;
    cell_out_t               cell_o [MAX_EDGES];
    logic [MAX_EDGES-1:0]    hit_vec;

    logic [TOT_W-1:0]        edge_total_reg, edge_total_next;
    logic [CNT_W-1:0]        under_reg, under_next;
    logic [CNT_W-1:0]        over_reg, over_next;
    logic [CNT_W-1:0]        samples_reg, samples_next;
    logic [IDX_W-1:0]        best_bin_reg, best_bin_next;
    logic [CNT_W-1:0]        best_count_reg, best_count_next;
    logic signed [VAL_W-1:0] mode_reg, mode_next;

    logic                    do_insert, do_count, do_clear;
    logic [IDX_W-1:0]        hit_idx;
    logic [CNT_W-1:0]        cnt_sel;
    logic signed [VAL_W-1:0] mid_sel;
    logic                    take_sel;
    logic                    in_bin;
    status_t                 status;
    result_t                 result;

    assign accept = s_valid && s_ready;

    always_comb begin
        do_insert = 1'b0;
        do_count  = 1'b0;
        do_clear  = 1'b0;
        case (s_data.action)
            ACT_CLEAR: do_clear  = accept;
            ACT_ADD:   do_insert = accept && (edge_total_reg < TOT_W'(MAX_EDGES))
                                   && (samples_reg == '0);
            ACT_COUNT: do_count  = accept && (edge_total_reg >= TOT_W'(2));
            default: ;
        endcase
    end

    always_comb begin
        ctrl.do_insert  = do_insert;
        ctrl.do_count   = do_count;
        ctrl.do_clear   = do_clear;
        ctrl.value      = (s_data.action == ACT_ADD) ? s_data.edge_value : s_data.sample;
        ctrl.edge_total = edge_total_reg;
        ctrl.best_bin   = best_bin_reg;
        ctrl.best_count = best_count_reg;
    end

    for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
        logic                    left_le;
        logic signed [VAL_W-1:0] left_edge;
        logic                    right_le;
        logic signed [VAL_W-1:0] right_edge;

        if (i == 0) begin : g_head
            assign left_le   = 1'b1;
            assign left_edge = '0;
        end else begin : g_link_l
            assign left_le   = cell_o[i-1].le;
            assign left_edge = cell_o[i-1].edge_cur;
        end

        if (i == MAX_EDGES - 1) begin : g_tail
            assign right_le   = 1'b0;
            assign right_edge = '0;
        end else begin : g_link_r
            assign right_le   = cell_o[i+1].le;
            assign right_edge = cell_o[i+1].edge_cur;
        end

        veh_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (IDX_W'(i)),
            .ctrl      (ctrl),
            .left_le   (left_le),
            .left_edge (left_edge),
            .right_le  (right_le),
            .right_edge(right_edge),
            .cell_o    (cell_o[i])
        );

        assign hit_vec[i] = cell_o[i].hit;
    end

    // at most one cell hits, so an or-reduction selects its values
    always_comb begin
        hit_idx  = '0;
        cnt_sel  = '0;
        mid_sel  = '0;
        take_sel = 1'b0;
        for (int i = 0; i < MAX_EDGES; i++) begin
            if (hit_vec[i]) begin
                hit_idx  = hit_idx | IDX_W'(i);
                cnt_sel  = cnt_sel | cell_o[i].cnt_new;
                mid_sel  = mid_sel | cell_o[i].mid;
                take_sel = take_sel | cell_o[i].take;
            end
        end
        in_bin = |hit_vec;
    end

    always_comb begin
        edge_total_next = edge_total_reg;
        under_next      = under_reg;
        over_next       = over_reg;
        samples_next    = samples_reg;
        best_bin_next   = best_bin_reg;
        best_count_next = best_count_reg;
        mode_next       = mode_reg;
        status          = ST_REFUSED;
        if (do_clear) begin
            edge_total_next = '0;
            under_next      = '0;
            over_next       = '0;
            samples_next    = '0;
            best_bin_next   = '0;
            best_count_next = '0;
            mode_next       = '0;
            status          = ST_CLEARED;
        end else if (do_insert) begin
            edge_total_next = edge_total_reg + TOT_W'(1);
            // no samples yet, so the peak stays on the first bin
            if (edge_total_next >= TOT_W'(2)) begin
                mode_next = mid_of(cell_o[0].edge_upd, cell_o[1].edge_upd);
            end
            status = ST_EDGE;
        end else if (do_count) begin
            samples_next = sat_inc(samples_reg);
            if (!cell_o[0].le) begin
                under_next = sat_inc(under_reg);
                status     = ST_UNDER;
            end else if (in_bin) begin
                status = ST_IN_BIN;
                if (take_sel) begin
                    best_bin_next   = hit_idx;
                    best_count_next = cnt_sel;
                    mode_next       = mid_sel;
                end
            end else begin
                over_next = sat_inc(over_reg);
                status    = ST_OVER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_total_reg <= '0;
            under_reg      <= '0;
            over_reg       <= '0;
            samples_reg    <= '0;
            best_bin_reg   <= '0;
            best_count_reg <= '0;
            mode_reg       <= '0;
        end else begin
            edge_total_reg <= edge_total_next;
            under_reg      <= under_next;
            over_reg       <= over_next;
            samples_reg    <= samples_next;
            best_bin_reg   <= best_bin_next;
            best_count_reg <= best_count_next;
            mode_reg       <= mode_next;
        end
    end

    always_comb begin
        result.status       = status;
        result.hit_bin      = (status == ST_IN_BIN) ? hit_idx : '0;
        result.peak_bin     = best_bin_next;
        result.peak_count   = best_count_next;
        result.mode_value   = mode_next;
        result.below_total  = under_next;
        result.above_total  = over_next;
        result.sample_total = samples_next;
        result.edges_held   = edge_total_next;
    end

    veh_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .push_ready(s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a sample lands in at most one bin
    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("more than one bin hit");

    // an accepted insert grows the edge count by exactly one
    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (edge_total_reg == $past(edge_total_reg) + TOT_W'(1)))
        else $error("edge count did not advance on insert");

    // the fullest bin never holds more than all samples together
    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        best_count_reg <= samples_reg)
        else $error("peak count exceeds sample total");

endmodule
`default_nettype wire

// ----- tb/veh_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// veh_checker
// Watches both channels of the variable-edge histogram. It keeps its own
// sorted edge list and bin counters, works out the result of every accepted
// transaction, and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
module veh_checker
    import veh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  result_t     m_data,
    output int unsigned mismatch_count,
    output int unsigned pending_count,
    output int unsigned results_checked,
    output int unsigned binned_seen,
    output int unsigned under_seen,
    output int unsigned over_seen,
    output int unsigned refused_seen,
    output int unsigned full_store_seen
);

    logic signed [VAL_W-1:0] edge_list [0:MAX_EDGES-1];
    logic [CNT_W-1:0]        bin_hits  [0:NUM_BINS-1];
    int                      edge_cnt;
    logic [CNT_W-1:0]        under_cnt;
    logic [CNT_W-1:0]        over_cnt;
    logic [CNT_W-1:0]        sample_cnt;

    result_t expected_results [$];

    initial begin
        mismatch_count  = 0;
        pending_count   = 0;
        results_checked = 0;
        binned_seen     = 0;
        under_seen      = 0;
        over_seen       = 0;
        refused_seen    = 0;
        full_store_seen = 0;
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    function automatic void histo_clear();
        edge_cnt   = 0;
        under_cnt  = '0;
        over_cnt   = '0;
        sample_cnt = '0;
        for (int i = 0; i < NUM_BINS; i++) bin_hits[i] = '0;
    endfunction

    // number of stored edges at or below v, i.e. the upper-bound position
    function automatic int count_le(input logic signed [VAL_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < edge_cnt; i++)
            if (edge_list[i] <= v) n = i + 1;
        return n;
    endfunction

    function automatic result_t histo_step(input in_item_t it);
        result_t                 r;
        logic signed [VAL_W-1:0] ev;
        logic signed [VAL_W-1:0] sv;
        int                      pos;
        int                      nb;
        int                      pk;
        logic [CNT_W-1:0]        pk_cnt;
        longint                  esum;
        r = '0;
        ev = it.edge_value;
        sv = it.sample;
        r.status = ST_REFUSED;
        case (it.action)
            ACT_CLEAR: begin
                histo_clear();
                r.status = ST_CLEARED;
            end
            ACT_ADD: begin
                if (edge_cnt < MAX_EDGES && sample_cnt == '0) begin
                    pos = count_le(ev);
                    for (int k = edge_cnt; k > pos; k--) edge_list[k] = edge_list[k-1];
                    edge_list[pos] = ev;
                    edge_cnt++;
                    r.status = ST_EDGE;
                end
            end
            ACT_COUNT: begin
                if (edge_cnt >= 2) begin
                    pos = count_le(sv);
                    if (pos == 0) begin
                        under_cnt = bump(under_cnt);
                        r.status = ST_UNDER;
                    end else if (pos >= edge_cnt) begin
                        over_cnt = bump(over_cnt);
                        r.status = ST_OVER;
                    end else begin
                        bin_hits[pos-1] = bump(bin_hits[pos-1]);
                        r.hit_bin = IDX_W'(pos - 1);
                        r.status = ST_IN_BIN;
                    end
                    sample_cnt = bump(sample_cnt);
                end
            end
            default: ;
        endcase

        // arg-max over live bins, lowest index wins ties
        nb = (edge_cnt >= 2) ? edge_cnt - 1 : 0;
        pk = 0;
        pk_cnt = '0;
        for (int i = 0; i < nb; i++) begin
            if (bin_hits[i] > pk_cnt) begin
                pk = i;
                pk_cnt = bin_hits[i];
            end
        end
        r.peak_bin   = IDX_W'(pk);
        r.peak_count = pk_cnt;
        if (edge_cnt >= 2) begin
            esum = longint'(edge_list[pk]) + longint'(edge_list[pk+1]);
            r.mode_value = VAL_W'(esum >>> 1);
        end
        r.below_total  = under_cnt;
        r.above_total  = over_cnt;
        r.sample_total = sample_cnt;
        r.edges_held   = TOT_W'(edge_cnt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            histo_clear();
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status",       32'(want.status),       32'(m_data.status));
                    check_field("hit_bin",      32'(want.hit_bin),      32'(m_data.hit_bin));
                    check_field("peak_bin",     32'(want.peak_bin),     32'(m_data.peak_bin));
                    check_field("peak_count",   want.peak_count,        m_data.peak_count);
                    check_field("mode_value",   want.mode_value,        m_data.mode_value);
                    check_field("below_total",  want.below_total,       m_data.below_total);
                    check_field("above_total",  want.above_total,       m_data.above_total);
                    check_field("sample_total", want.sample_total,      m_data.sample_total);
                    check_field("edges_held",   32'(want.edges_held),   32'(m_data.edges_held));
                    results_checked++;
                    case (want.status)
                        ST_IN_BIN:  binned_seen++;
                        ST_UNDER:   under_seen++;
                        ST_OVER:    over_seen++;
                        ST_REFUSED: refused_seen++;
                        default: ;
                    endcase
                    if (want.edges_held == TOT_W'(MAX_EDGES)) full_store_seen++;
                end
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), histo_step(s_data));
        end
        pending_count = expected_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the variable-edge histogram with a short directed run and then with
// random clear / add-edge / count-sample sequences under bursty input and a
// stalling output, and reports the verdict from the checker's findings.
// ----------------------------------------------------------------------------
module testbench;
    import veh_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int ITEM_TARGET    = 1200;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } rdy_mode_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_item_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    result_t  m_data;

    int unsigned mismatch_count, pending_count, results_checked;
    int unsigned binned_seen, under_seen, over_seen, refused_seen, full_store_seen;

    int unsigned items_sent   = 0;
    int          burst_left   = 0;
    int          idle_cycles  = 0;
    logic        hold_request = 1'b0;
    logic        hold_served  = 1'b0;

    variable_edge_histogram_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    veh_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .results_checked (results_checked),
        .binned_seen     (binned_seen),
        .under_seen      (under_seen),
        .over_seen       (over_seen),
        .refused_seen    (refused_seen),
        .full_store_seen (full_store_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // result side: randomly chosen stall patterns, plus one long hold
    initial begin : receiver
        rdy_mode_t ready_mode;
        int        mode_left;
        ready_mode = RDY_ALWAYS;
        mode_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    ready_mode = rdy_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(16, 128);
                end
                mode_left--;
                case (ready_mode)
                    RDY_ALWAYS:   m_ready <= 1'b1;
                    RDY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY:   m_ready <= ($urandom_range(0, 3) == 0);
                    default:      m_ready <= ((mode_left % 5) < 2);
                endcase
            end
        end
    end

    // one transaction, preceded by a random gap at the start of each burst
    task automatic send_item(input logic [1:0] act, input logic [31:0] ev,
                             input logic [31:0] sv);
        in_item_t it;
        int       gap_len;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_len > 0) begin
                s_valid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
        burst_left--;
        it.action     = act;
        it.edge_value = ev;
        it.sample     = sv;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    initial begin : stimulus
        logic signed [VAL_W-1:0] picked [0:17];
        logic signed [VAL_W-1:0] v;
        int                      n_edges, n_samples, shift, off_shift, seq_idx, roll;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty store, single edge, extreme edges and samples
        send_item(ACT_UNUSED, $urandom, $urandom);
        send_item(ACT_COUNT, $urandom, 32'sh0);
        send_item(ACT_ADD, Q_MAX, $urandom);
        send_item(ACT_COUNT, $urandom, 32'sh0);
        send_item(ACT_ADD, Q_MIN, $urandom);
        send_item(ACT_COUNT, $urandom, Q_MIN);
        send_item(ACT_COUNT, $urandom, Q_MAX);
        send_item(ACT_COUNT, $urandom, 32'shFFFF_FFFF);
        send_item(ACT_ADD, 32'sh0, $urandom);
        send_item(ACT_UNUSED, $urandom, $urandom);
        send_item(ACT_CLEAR, $urandom, $urandom);
        // duplicate edges, an insert at the front, an empty bin and a tie
        send_item(ACT_ADD, 32'sh0001_0000, $urandom);
        send_item(ACT_ADD, 32'sh0001_0000, $urandom);
        send_item(ACT_ADD, 32'sh0003_0000, $urandom);
        send_item(ACT_ADD, 32'shFFFF_0000, $urandom);
        send_item(ACT_COUNT, $urandom, 32'sh0001_0000);
        send_item(ACT_COUNT, $urandom, 32'sh0000_8000);
        send_item(ACT_COUNT, $urandom, 32'shFFFE_0000);
        send_item(ACT_COUNT, $urandom, 32'sh0002_FFFF);
        send_item(ACT_COUNT, $urandom, 32'sh0000_0000);
        send_item(ACT_CLEAR, $urandom, $urandom);

        seq_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            if (seq_idx == 3) hold_request = 1'b1;
            // now and then skip the clear so adds land after samples
            if ($urandom_range(0, 9) != 0) send_item(ACT_CLEAR, $urandom, $urandom);

            roll = $urandom_range(0, 99);
            if (seq_idx == 0)  n_edges = 17;
            else if (roll < 15) n_edges = $urandom_range(0, 1);
            else if (roll < 30) n_edges = $urandom_range(15, 18);
            else                n_edges = $urandom_range(2, 14);

            shift = $urandom_range(0, 28);
            off_shift = (shift + 2 > 31) ? 31 : shift + 2;
            for (int k = 0; k < n_edges; k++) begin
                if (k > 0 && $urandom_range(0, 4) == 0) v = picked[$urandom_range(0, k - 1)];
                else v = $signed($urandom) >>> shift;
                picked[k] = v;
                send_item(ACT_ADD, v, $urandom);
            end

            n_samples = $urandom_range(1, 40);
            for (int j = 0; j < n_samples; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    send_item(ACT_UNUSED, $urandom, $urandom);
                end else if (roll < 8) begin
                    send_item(ACT_ADD, $urandom, $urandom);
                end else begin
                    if (n_edges > 0 && roll < 30)
                        v = picked[$urandom_range(0, n_edges - 1)];
                    else if (n_edges > 0 && roll < 75)
                        v = picked[$urandom_range(0, n_edges - 1)]
                            + ($signed($urandom) >>> off_shift);
                    else if (roll < 90)
                        v = $urandom;
                    else
                        v = (roll % 2 == 0) ? Q_MAX : Q_MIN;
                    send_item(ACT_COUNT, $urandom, v);
                end
            end
            seq_idx++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d transactions in %0d sequences, %0d results checked",
                 items_sent, seq_idx, results_checked);
        $display("summary: %0d binned, %0d under, %0d over, %0d refused, %0d full-store",
                 binned_seen, under_seen, over_seen, refused_seen, full_store_seen);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- variable_edge_histogram_top.f -----
hdl/veh_pkg.sv
hdl/veh_cell.sv
hdl/veh_out_buf.sv
hdl/variable_edge_histogram_top.sv
tb/veh_checker.sv
tb/testbench.sv
